### src/b58enc_pkg.sv
package b58enc_pkg;

  // Block geometry and radix
  localparam int unsigned Radix     = 58;
  localparam int unsigned FullBytes = 8;
  localparam int unsigned FullChars = 11;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  // Number of characters for a block of the given byte count
  function automatic logic [3:0] chars_for_bytes(input logic [3:0] nbytes);
    logic [3:0] n;
    unique case (nbytes)
      4'd1:    n = 4'd2;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd5;
      4'd4:    n = 4'd6;
      4'd5:    n = 4'd7;
      4'd6:    n = 4'd9;
      4'd7:    n = 4'd10;
      4'd8:    n = 4'd11;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Map a base58 digit onto its ASCII character (Bitcoin alphabet)
  function automatic logic [6:0] symbol_of(input logic [5:0] digit);
    logic [6:0] c;
    priority if (digit <= 6'd8) begin
      c = 7'h31 + {1'b0, digit};
    end else if (digit <= 6'd16) begin
      c = 7'h41 + {1'b0, digit - 6'd9};
    end else if (digit <= 6'd21) begin
      c = 7'h4A + {1'b0, digit - 6'd17};
    end else if (digit <= 6'd32) begin
      c = 7'h50 + {1'b0, digit - 6'd22};
    end else if (digit <= 6'd43) begin
      c = 7'h61 + {1'b0, digit - 6'd33};
    end else if (digit <= 6'd57) begin
      c = 7'h6D + {1'b0, digit - 6'd44};
    end else begin
      c = 7'h31;
    end
    return c;
  endfunction

endpackage

### src/block_base58_encoder.sv
// Block base58 encoder. Bytes are taken one per request, most significant first, and
// gathered into blocks of eight. A byte that does not close a block is shifted into it.
// A byte that fills the block, or carries end_of_data, starts the conversion:
// one shared divide-by-58 unit consumes eight dividend bits per cycle, digit by digit,
// for a block of N characters (N = 2..11); then its characters leave at one per cycle
// through the output register while the output is not stalled by out_ready_i.
// No byte is taken from the start of the conversion until the last character of the
// block has been loaded.
module block_base58_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] symbol_o,
  output logic       end_of_text_o
);

  b58enc_pkg::state_e state_q, state_d;

  logic [63:0] val_q, val_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  nch_q, nch_d;
  logic        last_q, last_d;
  logic [2:0]  step_q, step_d;
  logic [3:0]  dig_q, dig_d;
  logic [5:0]  rem_q, rem_d;
  logic [3:0]  em_q, em_d;
  logic        out_valid_q, out_valid_d;
  logic [6:0]  sym_q, sym_d;
  logic        eot_q, eot_d;

  logic [5:0]  dig_buf_q [b58enc_pkg::FullChars];
  logic        buf_we;

  logic        in_acc;
  logic        out_load;
  logic [3:0]  count;
  logic [63:0] val_in;
  logic [6:0]  div_r;
  logic [7:0]  div_qb;

  assign in_ready_o    = (state_q == b58enc_pkg::StIdle);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_load      = !out_valid_q || out_ready_i;
  assign count         = {1'b0, cnt_q} + 4'd1;
  assign val_in        = {val_q[55:0], data_byte_i};
  assign out_valid_o   = out_valid_q;
  assign symbol_o      = sym_q;
  assign end_of_text_o = eot_q;

  // Eight restoring steps of the divide-by-58 unit
  always_comb begin
    div_r  = {1'b0, rem_q};
    div_qb = '0;
    for (int i = 0; i < 8; i++) begin
      div_r = {div_r[5:0], val_q[63-i]};
      if (div_r >= 7'(b58enc_pkg::Radix)) begin
        div_r         = div_r - 7'(b58enc_pkg::Radix);
        div_qb[7-i]   = 1'b1;
      end
    end
  end

  // Sequencer: gather, divide, emit
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    nch_d       = nch_q;
    last_d      = last_q;
    step_d      = step_q;
    dig_d       = dig_q;
    rem_d       = rem_q;
    em_d        = em_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sym_d       = sym_q;
    eot_d       = eot_q;
    buf_we      = 1'b0;

    unique case (state_q)
      b58enc_pkg::StIdle: begin
        if (in_acc) begin
          val_d = val_in;
          if (count == 4'(b58enc_pkg::FullBytes) || end_of_data_i) begin
            nch_d   = b58enc_pkg::chars_for_bytes(count);
            last_d  = end_of_data_i;
            dig_d   = b58enc_pkg::chars_for_bytes(count) - 4'd1;
            step_d  = '0;
            rem_d   = '0;
            state_d = b58enc_pkg::StDiv;
          end else begin
            cnt_d = count[2:0];
          end
        end
      end
      b58enc_pkg::StDiv: begin
        val_d  = {val_q[55:0], div_qb};
        rem_d  = div_r[5:0];
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          // Digit complete: store it and restart the remainder
          buf_we = 1'b1;
          rem_d  = '0;
          if (dig_q == 4'd0) begin
            em_d    = '0;
            state_d = b58enc_pkg::StEmit;
          end else begin
            dig_d = dig_q - 4'd1;
          end
        end
      end
      b58enc_pkg::StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          sym_d       = b58enc_pkg::symbol_of(dig_buf_q[em_q]);
          eot_d       = last_q && (em_q == nch_q - 4'd1);
          em_d        = em_q + 4'd1;
          if (em_q == nch_q - 4'd1) begin
            cnt_d   = '0;
            val_d   = '0;
            state_d = b58enc_pkg::StIdle;
          end
        end
      end
      default: state_d = b58enc_pkg::StIdle;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b58enc_pkg::StIdle;
      val_q       <= '0;
      cnt_q       <= '0;
      nch_q       <= '0;
      last_q      <= 1'b0;
      step_q      <= '0;
      dig_q       <= '0;
      rem_q       <= '0;
      em_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      val_q       <= val_d;
      cnt_q       <= cnt_d;
      nch_q       <= nch_d;
      last_q      <= last_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      rem_q       <= rem_d;
      em_q        <= em_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the output payload and the digit buffer
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    eot_q <= eot_d;
    if (buf_we) begin
      dig_buf_q[dig_q] <= div_r[5:0];
    end
  end

  // A byte with end_of_data starts a conversion, so no byte follows in the next cycle
  a_close_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_data_i |=> !in_ready_o)
    else $error("byte taken during conversion");

  // Every quotient has drained to zero once all digits are stored
  a_quot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == b58enc_pkg::StEmit |-> val_q == 64'd0)
    else $error("block value exceeds its digit count");

  // Digit index stays within the buffer while dividing
  a_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == b58enc_pkg::StDiv |-> dig_q < 4'(b58enc_pkg::FullChars))
    else $error("digit index out of range");

  // End of text, when loaded into an empty output register, only for a final block
  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d && !out_valid_q && eot_d |-> last_q)
    else $error("end of text on a non-final block");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  // Watchdog: cycles without any accepted request or character
  localparam int unsigned StallLimit  = 2000;
  // Quiet cycles after the last expected character
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned RandomBytes = 135;
  localparam int unsigned IdlePercent = 12;

  // Expected-character store and encoder prediction
  class b58_scoreboard;
    typedef struct packed {
      logic [6:0] symbol;
      logic       eot;
    } char_t;

    logic [63:0] open_block;
    int unsigned open_bytes;
    char_t       char_q[$];
    int unsigned errors;
    int unsigned chars_checked;
    int unsigned whole_blocks;
    int unsigned short_blocks;
    int unsigned messages;

    function new();
      open_block = '0;
      open_bytes = 0;
      errors = 0;
      chars_checked = 0;
      whole_blocks = 0;
      short_blocks = 0;
      messages = 0;
    endfunction

    // Print one line per mismatch and count it
    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Bitcoin alphabet lookup
    function logic [6:0] digit_char(int unsigned d);
      logic [8*58-1:0] alphabet;
      alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      return alphabet[8*(57-d) +: 7];
    endfunction

    function int unsigned block_chars(int unsigned nbytes);
      case (nbytes)
        1: return 2;
        2: return 3;
        3: return 5;
        4: return 6;
        5: return 7;
        6: return 9;
        7: return 10;
        default: return 11;
      endcase
    endfunction

    // Fold an accepted byte into the open block; close it when full or final
    function void note_request(logic [7:0] data, logic last);
      logic [63:0] value;
      int unsigned count;
      int unsigned nchars;
      int i;
      logic [6:0] chars [11];
      count = open_bytes + 1;
      value = {open_block[55:0], data};
      if (count == 8 || last) begin
        nchars = block_chars(count);
        for (i = nchars - 1; i >= 0; i--) begin
          chars[i] = digit_char(int'(value % 64'd58));
          value = value / 64'd58;
        end
        for (i = 0; i < nchars; i++) begin
          char_q.push_back('{symbol: chars[i], eot: last && (i == nchars - 1)});
        end
        if (count == 8) whole_blocks++;
        else short_blocks++;
        if (last) messages++;
        open_block = '0;
        open_bytes = 0;
      end else begin
        open_block = value;
        open_bytes = count;
      end
    endfunction

    // Compare an accepted character with the oldest expectation
    task check_result(logic [6:0] symbol, logic eot);
      char_t want;
      if (char_q.size() == 0) begin
        report($sformatf("unexpected character 0x%02h eot=%0b", symbol, eot));
        return;
      end
      want = char_q.pop_front();
      chars_checked++;
      if (symbol !== want.symbol)
        report($sformatf("symbol 0x%02h, want 0x%02h ('%c')", symbol, want.symbol,
                         want.symbol));
      if (eot !== want.eot)
        report($sformatf("end_of_text %0b, want %0b on '%c'", eot, want.eot, want.symbol));
    endtask

    function int unsigned pending();
      return char_q.size();
    endfunction

    // Flag whatever never arrived
    task drain();
      if (char_q.size() != 0)
        report($sformatf("%0d characters never arrived", char_q.size()));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] symbol;
  logic       end_of_text;

  b58_scoreboard sb = new();
  logic          calm;
  int unsigned   bytes_sent;
  int unsigned   quiet_cycles = 0;

  block_base58_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .end_of_data_i(end_of_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .symbol_o     (symbol),
    .end_of_text_o(end_of_text)
  );

  // Clock
  always #4 clk_i = ~clk_i;

  // Stall the output side at random, except in the quiet stretch
  always @(negedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Note accepted requests and check accepted characters
  always @(posedge clk_i) begin
    if (in_valid && in_ready) sb.note_request(data_byte, end_of_data);
    if (out_valid && out_ready) sb.check_result(symbol, end_of_text);
  end

  // Watchdog on cycles without progress
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == StallLimit) begin
      $display("timeout: no progress for %0d cycles", StallLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one byte, idling at random first; return on the falling edge after acceptance
  task automatic send_byte(input logic [7:0] data, input logic last);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    data_byte   <= data;
    end_of_data <= last;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Repeat one byte value, flagging the final one if asked
  task automatic send_run(input logic [7:0] data, input int unsigned n, input logic last);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(data, last && (i == n - 1));
  endtask

  // Random message content, leaning on the byte extremes now and then
  task automatic send_message(input int unsigned len);
    int unsigned i;
    logic [7:0] data;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0: data = 8'h00;
        1: data = 8'hFF;
        default: data = 8'($urandom_range(255));
      endcase
      send_byte(data, i == len - 1);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned random_start;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    data_byte   = '0;
    end_of_data = 1'b0;
    out_ready   = 1'b0;
    calm        = 1'b0;
    bytes_sent  = 0;

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: one-byte extremes, the longest short block, full blocks both ways
    send_run(8'h00, 1, 1'b1);
    send_run(8'hFF, 1, 1'b1);
    send_run(8'hFF, 7, 1'b1);
    send_run(8'h00, 8, 1'b0);
    send_run(8'hFF, 8, 1'b1);

    // Random messages, mostly short so every short block length recurs
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      calm = (bytes_sent - random_start >= 70) && (bytes_sent - random_start < 120);
      if ($urandom_range(3) == 0) len = $urandom_range(9, 24);
      else len = $urandom_range(1, 8);
      send_message(len);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Wait for every expected character, then make sure nothing else follows
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.drain();

    $display("covered %0d bytes in %0d messages: %0d full and %0d short blocks",
             bytes_sent, sb.messages, sb.whole_blocks, sb.short_blocks);
    $display("checked %0d characters, %0d mismatches", sb.chars_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/b58enc_pkg.sv
src/block_base58_encoder.sv
sim/tb.sv
